>>> hdl/cfd_pkg.sv
package cfd_pkg;

    // Parser phase of the deframer.
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_SUM  = 2'd3
    } t_phase;

    // Kind of a result request.
    typedef enum logic [1:0] {
        KIND_TYPE    = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    // Configuration register indexes.
    localparam logic REG_DELIMITER = 1'b0;
    localparam logic REG_MAX_LEN   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] DELIMITER_RESET = 8'd126;
    localparam logic [7:0] MAX_LEN_RESET   = 8'd255;

    // Length used when the length byte exceeds the maximum.
    localparam logic [7:0] CLAMP_LEN = 8'd4;

    // Sum that marks a good checksum.
    localparam logic [7:0] GOOD_SUM = 8'hFF;

    // One result request.
    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      byte_kind;
        logic [7:0] byte_position;
        logic [7:0] frame_length;
        logic       frame_end;
        logic       checksum_good;
    } t_result;

endpackage

>>> hdl/checksummed_frame_deframer.sv
// A body or checksum byte registers its result request in the output register or skid stage.
// Throughput: one received byte per cycle while the skid stage is empty; the output register
// plus a skid stage keep the input open while a finished result waits to be taken.
// Delimiter and length bytes give no result.
// Reset (synchronous, active low) returns the parser to delimiter hunting, clears the
// output and skid valid flags and restores delimiter 126 and maximum length 255.
module checksummed_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received byte stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [15:8] byte_position,
                                        // [23:16] frame_length
    output logic [2:0]  m_axis_tuser,   // [1:0] byte_kind, [2] checksum_good
    output logic        m_axis_tlast,   // frame_end
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [7:0] r_delimiter;
    logic [7:0] r_max_len;
    logic       cfg_write;
    logic       cfg_index;

    // Parser state.
    cfd_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_len, n_len;
    logic [7:0]      r_seen, n_seen;
    logic [7:0]      r_sum, n_sum;

    // Result path.
    logic             in_take;
    logic             res_valid;
    cfd_pkg::t_result res;
    logic             r_out_valid;
    cfd_pkg::t_result r_out;
    logic             r_skid_valid;
    cfd_pkg::t_result r_skid;
    logic             out_free;

    logic [7:0] clamped_len;
    logic [7:0] seen_next;
    logic [7:0] sum_next;

    // Configuration write and read.
    assign pready    = 1'b1;
    assign cfg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delimiter <= cfd_pkg::DELIMITER_RESET;
            r_max_len   <= cfd_pkg::MAX_LEN_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                cfd_pkg::REG_DELIMITER: r_delimiter <= pwdata[7:0];
                cfd_pkg::REG_MAX_LEN:   r_max_len   <= pwdata[7:0];
                default:                r_delimiter <= r_delimiter;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            cfd_pkg::REG_DELIMITER: prdata = {24'd0, r_delimiter};
            cfd_pkg::REG_MAX_LEN:   prdata = {24'd0, r_max_len};
            default:                prdata = 32'd0;
        endcase
    end

    // Input handshake: the skid stage must be free to take a request.
    assign s_axis_tready = !r_skid_valid;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Shared arithmetic for the byte at the input.
    assign clamped_len = (s_axis_tdata > r_max_len) ? cfd_pkg::CLAMP_LEN : s_axis_tdata;
    assign seen_next   = 8'(r_seen + 8'd1);
    assign sum_next    = 8'(r_sum + s_axis_tdata);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (in_take) begin
            unique case (r_phase)
                cfd_pkg::PH_HUNT:
                    if (s_axis_tdata == r_delimiter) n_phase = cfd_pkg::PH_LEN;
                cfd_pkg::PH_LEN:
                    n_phase = (clamped_len == 8'd0) ? cfd_pkg::PH_SUM : cfd_pkg::PH_BODY;
                cfd_pkg::PH_BODY:
                    if (seen_next == r_len) n_phase = cfd_pkg::PH_SUM;
                cfd_pkg::PH_SUM:
                    n_phase = cfd_pkg::PH_HUNT;
                default:
                    n_phase = cfd_pkg::PH_HUNT;
            endcase
        end
    end

    // Counters, running sum and the result request of the current byte.
    always_comb begin
        n_len     = r_len;
        n_seen    = r_seen;
        n_sum     = r_sum;
        res_valid = 1'b0;
        res.out_byte      = s_axis_tdata;
        res.byte_kind     = cfd_pkg::KIND_PAYLOAD;
        res.byte_position = r_seen;
        res.frame_length  = r_len;
        res.frame_end     = 1'b0;
        res.checksum_good = 1'b0;
        if (in_take) begin
            unique case (r_phase)
                cfd_pkg::PH_HUNT: begin
                    n_len = r_len;
                end
                cfd_pkg::PH_LEN: begin
                    n_len  = clamped_len;
                    n_seen = 8'd0;
                    n_sum  = clamped_len;
                end
                cfd_pkg::PH_BODY: begin
                    res_valid     = 1'b1;
                    res.byte_kind = (r_seen == 8'd0) ? cfd_pkg::KIND_TYPE
                                                     : cfd_pkg::KIND_PAYLOAD;
                    n_sum         = sum_next;
                    n_seen        = seen_next;
                end
                cfd_pkg::PH_SUM: begin
                    res_valid         = 1'b1;
                    res.byte_kind     = cfd_pkg::KIND_END;
                    res.frame_end     = 1'b1;
                    res.checksum_good = (sum_next == cfd_pkg::GOOD_SUM);
                    n_len             = 8'd0;
                    n_seen            = 8'd0;
                    n_sum             = 8'd0;
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= cfd_pkg::PH_HUNT;
            r_len   <= 8'd0;
            r_seen  <= 8'd0;
            r_sum   <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_sum   <= n_sum;
        end
    end

    // Output register with skid stage behind it.
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || res_valid;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.frame_length, r_out.byte_position, r_out.out_byte};
    assign m_axis_tuser  = {r_out.checksum_good, r_out.byte_kind};
    assign m_axis_tlast  = r_out.frame_end;

    // A held skid request always has a request ahead of it in the output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid request held without an output request");

    // Frame end only comes with the end of frame kind.
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_end) |-> (r_out.byte_kind == cfd_pkg::KIND_END))
        else $error("frame end on a body request");

    // Body requests never report a checksum result.
    a_body_no_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.frame_end) |-> !r_out.checksum_good)
        else $error("checksum flag on a body request");

    // While in the body the length is nonzero and the count is below it.
    a_body_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cfd_pkg::PH_BODY) |-> (r_len != 8'd0 && r_seen < r_len))
        else $error("body phase with bad length or count");

    // Hunting always starts from cleared frame state.
    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == cfd_pkg::PH_HUNT) |-> (r_len == 8'd0 && r_seen == 8'd0 && r_sum == 8'd0))
        else $error("frame state not cleared while hunting");

endmodule

>>> tb/tb.sv
module tb;

    // Clock, reset and block ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;      // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;             // [7:0] out_byte, [15:8] byte_position,
                                           // [23:16] frame_length
    logic [2:0]  m_axis_tuser;             // [1:0] byte_kind, [2] checksum_good
    logic        m_axis_tlast;             // frame_end
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Bytes waiting to be sent and results waiting to be seen.
    logic [7:0]       pending_bytes[$];
    cfd_pkg::t_result expected_results[$];

    // Configuration as the deframer should hold it.
    logic [7:0] cfg_delim = cfd_pkg::DELIMITER_RESET;
    logic [7:0] cfg_max = cfd_pkg::MAX_LEN_RESET;

    // Parser state of the deframer as predicted.
    cfd_pkg::t_phase parse_state = cfd_pkg::PH_HUNT;
    logic [7:0] body_len = 8'd0;
    logic [7:0] body_seen = 8'd0;
    logic [7:0] byte_sum = 8'd0;

    // Bit 0 lets the sender idle, bit 1 lets the receiver stall.
    logic [1:0] idle_mode = 2'b11;

    int   rx_total = 0;
    int   rx_sent = 0;
    int   results_seen = 0;
    int   frames_seen = 0;
    int   settings_used = 1;
    int   error_count = 0;
    bit   rx_taken = 1'b0;
    bit   rx_busy = 1'b0;
    int   rx_gap = 0;
    int   result_wait = 0;
    logic [7:0] rx_byte_cur = 8'd0;

    checksummed_frame_deframer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // Cycles a side waits before its next request.
    function automatic int draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, 19) : 0;
    endfunction

    // Predicts what one accepted received byte produces.
    task automatic deframe_byte(input logic [7:0] b);
        cfd_pkg::t_result r;
        logic [7:0]       len;
        r = '0;
        case (parse_state)
            cfd_pkg::PH_HUNT: begin
                if (b == cfg_delim) parse_state = cfd_pkg::PH_LEN;
            end
            cfd_pkg::PH_LEN: begin
                len = (b > cfg_max) ? cfd_pkg::CLAMP_LEN : b;
                body_len = len;
                body_seen = 8'd0;
                byte_sum = len;
                parse_state = (len == 8'd0) ? cfd_pkg::PH_SUM : cfd_pkg::PH_BODY;
            end
            cfd_pkg::PH_BODY: begin
                r.out_byte = b;
                r.byte_kind = (body_seen == 8'd0) ? cfd_pkg::KIND_TYPE
                                                  : cfd_pkg::KIND_PAYLOAD;
                r.byte_position = body_seen;
                r.frame_length = body_len;
                expected_results.push_back(r);
                byte_sum = byte_sum + b;
                body_seen = body_seen + 8'd1;
                if (body_seen == body_len) parse_state = cfd_pkg::PH_SUM;
            end
            default: begin
                byte_sum = byte_sum + b;
                r.out_byte = b;
                r.byte_kind = cfd_pkg::KIND_END;
                r.byte_position = body_seen;
                r.frame_length = body_len;
                r.frame_end = 1'b1;
                r.checksum_good = (byte_sum == cfd_pkg::GOOD_SUM);
                expected_results.push_back(r);
                parse_state = cfd_pkg::PH_HUNT;
                body_len = 8'd0;
                body_seen = 8'd0;
                byte_sum = 8'd0;
            end
        endcase
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Monitor: checks result requests, then feeds accepted bytes to the predictor.
    always @(posedge i_clk) begin
        cfd_pkg::t_result exp_r;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                result_wait = draw_wait(idle_mode[1]);
                results_seen++;
                if (m_axis_tlast) frames_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, got data 0x%0h user 0x%0h last %0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("out_byte", exp_r.out_byte, m_axis_tdata[7:0]);
                    check_field("byte_kind", exp_r.byte_kind, m_axis_tuser[1:0]);
                    check_field("byte_position", exp_r.byte_position, m_axis_tdata[15:8]);
                    check_field("frame_length", exp_r.frame_length, m_axis_tdata[23:16]);
                    check_field("frame_end", exp_r.frame_end, m_axis_tlast);
                    check_field("checksum_good", exp_r.checksum_good, m_axis_tuser[2]);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rx_taken = 1'b1;
                rx_sent++;
                deframe_byte(s_axis_tdata);
            end
        end
    end

    // Driver: sends pending bytes with random gaps and stalls the result side.
    always @(negedge i_clk) begin
        if (rx_taken) begin
            rx_taken = 1'b0;
            rx_busy = 1'b0;
            rx_gap = draw_wait(idle_mode[0]);
        end
        if (!rx_busy) begin
            if (rx_gap > 0) begin
                rx_gap--;
            end else if (pending_bytes.size() > 0) begin
                rx_byte_cur = pending_bytes.pop_front();
                rx_busy = 1'b1;
            end
        end
        s_axis_tvalid <= rx_busy;
        s_axis_tdata <= rx_busy ? rx_byte_cur : 8'($urandom);
        m_axis_tready <= (result_wait == 0);
        if (result_wait > 0) result_wait--;
    end

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        rx_total++;
    endtask

    // One frame under the current settings; delim_pct is the share of body
    // bytes that repeat the delimiter.
    task automatic push_frame(input logic [7:0] len_byte, input bit good, input int delim_pct);
        logic [7:0] len_used;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] cs;
        len_used = (len_byte > cfg_max) ? cfd_pkg::CLAMP_LEN : len_byte;
        sum = len_used;
        push_byte(cfg_delim);
        push_byte(len_byte);
        for (int i = 0; i < len_used; i++) begin
            b = ($urandom_range(0, 99) < delim_pct) ? cfg_delim : 8'($urandom);
            sum = sum + b;
            push_byte(b);
        end
        cs = cfd_pkg::GOOD_SUM - sum;
        if (!good) cs = cs ^ 8'($urandom_range(1, 255));
        push_byte(cs);
    endtask

    // Line noise between frames; a stray delimiter slips through now and then.
    task automatic push_noise();
        logic [7:0] b;
        int n;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            b = 8'($urandom);
            if (b == cfg_delim && $urandom_range(0, 9) != 0) b = ~b;
            push_byte(b);
        end
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = addr;
        pwdata = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Writes a register, reads it back and updates the predicted settings.
    task automatic write_register(input logic idx, input logic [7:0] value);
        logic [31:0] rd;
        apb_access(1'b1, {idx, 2'b00}, {24'd0, value}, rd);
        apb_access(1'b0, {idx, 2'b00}, 32'd0, rd);
        check_field(idx == cfd_pkg::REG_DELIMITER ? "delimiter readback"
                                                  : "max length readback",
                    value, rd[7:0]);
        if (idx == cfd_pkg::REG_DELIMITER) cfg_delim = value;
        else cfg_max = value;
    endtask

    // Holds off until every byte is taken and every result has come.
    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((rx_sent != rx_total || expected_results.size() != 0) && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        if (guard >= 200000) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            error_count++;
            expected_results.delete();
        end
        repeat (5) @(negedge i_clk);
    endtask

    initial begin
        logic [7:0] d;
        logic [7:0] m;
        logic [7:0] len_byte;
        logic [1:0] mode;
        int phase_start;
        int pick;

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: dropped noise, zero length, delimiter inside the body,
        // bad checksum.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_frame(8'd0, 1'b1, 0);
        push_frame(8'd2, 1'b1, 100);
        push_frame(8'd1, 1'b0, 0);
        wait_drained();

        // Length above a maximum of one is clamped to four; the length equals the delimiter.
        write_register(cfd_pkg::REG_DELIMITER, 8'h02);
        write_register(cfd_pkg::REG_MAX_LEN, 8'd1);
        settings_used++;
        push_frame(8'h02, 1'b1, 0);
        wait_drained();

        // Maximum of zero: any nonzero length becomes four, zero still passes.
        write_register(cfd_pkg::REG_DELIMITER, 8'hFF);
        write_register(cfd_pkg::REG_MAX_LEN, 8'd0);
        settings_used++;
        push_frame(8'hFF, 1'b1, 0);
        push_frame(8'd0, 1'b0, 0);
        wait_drained();

        // Random frames under a series of settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin d = 8'h00; m = 8'hFF; mode = 2'b00; end
                1: begin d = 8'hFF; m = 8'h01; mode = 2'b11; end
                2: begin d = 8'($urandom); m = 8'($urandom_range(1, 255)); mode = 2'b01; end
                3: begin d = 8'h7E; m = 8'd16; mode = 2'b10; end
                4: begin d = 8'($urandom); m = 8'hFF; mode = 2'b11; end
                default: begin
                    d = 8'($urandom);
                    m = 8'($urandom_range(1, 255));
                    mode = 2'b11;
                end
            endcase
            write_register(cfd_pkg::REG_DELIMITER, d);
            write_register(cfd_pkg::REG_MAX_LEN, m);
            settings_used++;
            idle_mode = mode;
            phase_start = rx_total;
            while (rx_total - phase_start < 200) begin
                push_noise();
                pick = $urandom_range(0, 99);
                if (pick < 65) len_byte = 8'($urandom_range(0, 10));
                else if (pick < 90) len_byte = 8'($urandom_range(0, 40));
                else len_byte = 8'($urandom);
                push_frame(len_byte, $urandom_range(0, 99) < 80, 5);
            end
            wait_drained();
        end

        $display("Sent %0d bytes under %0d register settings.", rx_total, settings_used);
        $display("Checked %0d results closing %0d frames.", results_seen, frames_seen);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #10000000;
        $display("%0t: timeout with %0d bytes unsent and %0d results missing", $time,
                 rx_total - rx_sent, expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
